>>> src/pfo_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pfo_pkg
// Shared types for the out-side-long projection pipeline.
// ----------------------------------------------------------------------------
package pfo_pkg;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_ZERO_PT  = 2'd1,
    STATUS_BAD_MASS = 2'd2
  } status_t;

  // sign and status bits that ride alongside the wide datapath
  typedef struct packed {
    status_t status;
    logic    a_neg;
    logic    s_neg;
    logic    l_neg;
    logic    d_neg;
  } side_t;

endpackage
`default_nettype wire

>>> src/pfo_delay.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pfo_delay
// Enabled shift line that keeps sideband data aligned with a pipelined unit.
// ----------------------------------------------------------------------------
module pfo_delay #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic [WIDTH-1:0] d_i,
  output logic      [WIDTH-1:0] q_o
);

  logic [WIDTH-1:0] tap_r [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      tap_r[0] <= d_i;
    end
  end

  for (genvar k = 1; k < DEPTH; k++) begin : g_tap
    always_ff @(posedge clk) begin
      if (en) begin
        tap_r[k] <= tap_r[k-1];
      end
    end
  end

  assign q_o = tap_r[DEPTH-1];

endmodule
`default_nettype wire

>>> src/pfo_sqrt_pipe.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pfo_sqrt_pipe
// Floor square root, one root bit per pipeline stage.
// ----------------------------------------------------------------------------
module pfo_sqrt_pipe #(
  parameter int RW = 64
) (
  input  wire logic            clk,
  input  wire logic            en,
  input  wire logic [RW-1:0]   rad_i,
  output logic      [RW/2-1:0] root_o
);

  localparam int RT = RW / 2;

  logic [RW-1:0] rem_r  [RT];
  logic [RT-1:0] root_r [RT];

  for (genvar k = 0; k < RT; k++) begin : g_stage
    localparam int B = RT - 1 - k;
    logic [RW-1:0] rem_in;
    logic [RT-1:0] root_in;
    logic [RW:0]   test;
    logic [RW:0]   rem_ext;
    logic [RW:0]   rem_nxt;

    if (k == 0) begin : g_first
      assign rem_in  = rad_i;
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
    end

    always_comb begin
      test    = ({{(RW+1-RT){1'b0}}, root_in} << (B + 1)) + ((RW+1)'(1) << (2 * B));
      rem_ext = {1'b0, rem_in};
      rem_nxt = rem_ext - test;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (rem_ext >= test) begin
          rem_r[k]  <= rem_nxt[RW-1:0];
          root_r[k] <= root_in | (RT'(1) << B);
        end else begin
          rem_r[k]  <= rem_in;
          root_r[k] <= root_in;
        end
      end
    end
  end

  assign root_o = root_r[RT-1];

endmodule
`default_nettype wire

>>> src/pfo_div_pipe.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pfo_div_pipe
// Unsigned restoring divider, one quotient bit per pipeline stage.
// ----------------------------------------------------------------------------
module pfo_div_pipe #(
  parameter int NW = 65,
  parameter int DW = 32
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [NW-1:0] num_i,
  input  wire logic [DW-1:0] den_i,
  output logic      [NW-1:0] quo_o
);

  // numerator bits shift out the top while quotient bits shift in below
  logic [NW-1:0] nq_r  [NW];
  logic [DW-1:0] rem_r [NW];
  logic [DW-1:0] den_r [NW];

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic [NW-1:0] nq_in;
    logic [DW-1:0] rem_in;
    logic [DW-1:0] den_in;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;

    if (k == 0) begin : g_first
      assign nq_in  = num_i;
      assign rem_in = '0;
      assign den_in = den_i;
    end else begin : g_next
      assign nq_in  = nq_r[k-1];
      assign rem_in = rem_r[k-1];
      assign den_in = den_r[k-1];
    end

    always_comb begin
      trial = {rem_in, nq_in[NW-1]};
      diff  = trial - {1'b0, den_in};
      ge    = trial >= {1'b0, den_in};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        nq_r[k]  <= {nq_in[NW-2:0], ge};
        rem_r[k] <= ge ? diff[DW-1:0] : trial[DW-1:0];
        den_r[k] <= den_in;
      end
    end
  end

  assign quo_o = nq_r[NW-1];

endmodule
`default_nettype wire

>>> src/pair_frame_out_side_long_projection.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pair_frame_out_side_long_projection
// Out/side/long projection of a separation vector in the pair frame.
// ----------------------------------------------------------------------------
// Fully pipelined: one request per clock unless the output stalls. The
// pipeline is the bit-per-stage square root (WORD_BITS stages) followed by
// the bit-per-stage dividers (2*WORD_BITS+1 stages), plus three stages of
// products, sums and sign-magnitude before them and three of rate multiply,
// subtract and saturation after them. A result-side stall with a result
// waiting freezes the whole pipeline; bubbles are kept, nothing is lost.
// ----------------------------------------------------------------------------
module pair_frame_out_side_long_projection #(
  parameter int FRAC_BITS = 16,
  parameter int WORD_BITS = 32
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic signed [WORD_BITS-1:0] in_sum_px,
  input  wire logic signed [WORD_BITS-1:0] in_sum_py,
  input  wire logic signed [WORD_BITS-1:0] in_sum_pz,
  input  wire logic signed [WORD_BITS-1:0] in_sum_energy,
  input  wire logic signed [WORD_BITS-1:0] in_vec_x,
  input  wire logic signed [WORD_BITS-1:0] in_vec_y,
  input  wire logic signed [WORD_BITS-1:0] in_vec_z,
  input  wire logic signed [WORD_BITS-1:0] in_vec_t,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic signed [WORD_BITS-1:0]      out_out_rest,
  output logic signed [WORD_BITS-1:0]      out_side_part,
  output logic signed [WORD_BITS-1:0]      out_long_part,
  output pfo_pkg::status_t                 out_status
);
  import pfo_pkg::*;

  localparam int W   = WORD_BITS;
  localparam int F   = FRAC_BITS;
  localparam int PW  = 2 * W;
  localparam int SW  = 2 * W + 2;
  localparam int QW  = 2 * W + 1;
  localparam int H   = W + 1;
  localparam int TW  = QW + 3;
  localparam int LAT = 3 + W + QW + 3;
  localparam int SBW = $bits(side_t);

  localparam logic [QW-1:0] MAG_POS_MAX = {{(QW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic [QW-1:0] MAG_NEG_MAX = {{(QW-W){1'b0}}, 1'b1, {(W-1){1'b0}}};
  localparam logic signed [TW-1:0] SAT_HI = {{(TW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [TW-1:0] SAT_LO = {{(TW-W+1){1'b1}}, {(W-1){1'b0}}};

  function automatic logic [W-1:0] sat_mag(input logic neg, input logic [QW-1:0] mag);
    logic [W-1:0] res;
    if (!neg) begin
      res = (mag > MAG_POS_MAX) ? {1'b0, {(W-1){1'b1}}} : mag[W-1:0];
    end else begin
      res = (mag > MAG_NEG_MAX) ? {1'b1, {(W-1){1'b0}}} : ~mag[W-1:0] + 1'b1;
    end
    return res;
  endfunction

  logic           adv;
  logic [LAT-1:0] vld_r;

  assign adv      = !vld_r[LAT-1] || !out_stall;
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  // stage 1: products
  logic signed [PW-1:0] s1_px2_r, s1_py2_r, s1_pz2_r, s1_e2_r;
  logic signed [PW-1:0] s1_vxpx_r, s1_vypy_r, s1_vypx_r, s1_vxpy_r;
  logic signed [PW-1:0] s1_vze_r, s1_vtpz_r, s1_evt_r, s1_pzvz_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_px2_r  <= in_sum_px * in_sum_px;
      s1_py2_r  <= in_sum_py * in_sum_py;
      s1_pz2_r  <= in_sum_pz * in_sum_pz;
      s1_e2_r   <= in_sum_energy * in_sum_energy;
      s1_vxpx_r <= in_vec_x * in_sum_px;
      s1_vypy_r <= in_vec_y * in_sum_py;
      s1_vypx_r <= in_vec_y * in_sum_px;
      s1_vxpy_r <= in_vec_x * in_sum_py;
      s1_vze_r  <= in_vec_z * in_sum_energy;
      s1_vtpz_r <= in_vec_t * in_sum_pz;
      s1_evt_r  <= in_sum_energy * in_vec_t;
      s1_pzvz_r <= in_sum_pz * in_vec_z;
    end
  end

  // stage 2: sums
  logic signed [SW-1:0] s2_pt2_r, s2_mt2_r, s2_m2_r;
  logic signed [SW-1:0] s2_a_r, s2_s_r, s2_l_r, s2_d_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_pt2_r <= SW'(s1_px2_r) + SW'(s1_py2_r);
      s2_mt2_r <= SW'(s1_e2_r) - SW'(s1_pz2_r);
      s2_m2_r  <= SW'(s1_e2_r) - SW'(s1_pz2_r) - SW'(s1_px2_r) - SW'(s1_py2_r);
      s2_a_r   <= SW'(s1_vxpx_r) + SW'(s1_vypy_r);
      s2_s_r   <= SW'(s1_vypx_r) - SW'(s1_vxpy_r);
      s2_l_r   <= SW'(s1_vze_r) - SW'(s1_vtpz_r);
      s2_d_r   <= SW'(s1_evt_r) - SW'(s1_vxpx_r) - SW'(s1_vypy_r) - SW'(s1_pzvz_r);
    end
  end

  // stage 3: status, radicands, sign-magnitude
  side_t          s3_side_nxt, s3_side_r;
  logic [PW-1:0]  s3_rad_pt_r, s3_rad_mt_r, s3_rad_m_r;
  logic [QW-1:0]  s3_a_r, s3_s_r, s3_l_r, s3_d_r;
  logic [SW-1:0]  a_abs, s_abs, l_abs, d_abs;

  always_comb begin
    s3_side_nxt.status = STATUS_OK;
    if (s2_pt2_r == '0) begin
      s3_side_nxt.status = STATUS_ZERO_PT;
    end else if (s2_m2_r[SW-1] || s2_m2_r == '0) begin
      s3_side_nxt.status = STATUS_BAD_MASS;
    end
    s3_side_nxt.a_neg = s2_a_r[SW-1];
    s3_side_nxt.s_neg = s2_s_r[SW-1];
    s3_side_nxt.l_neg = s2_l_r[SW-1];
    s3_side_nxt.d_neg = s2_d_r[SW-1];
    a_abs = s2_a_r[SW-1] ? -s2_a_r : s2_a_r;
    s_abs = s2_s_r[SW-1] ? -s2_s_r : s2_s_r;
    l_abs = s2_l_r[SW-1] ? -s2_l_r : s2_l_r;
    d_abs = s2_d_r[SW-1] ? -s2_d_r : s2_d_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_side_r   <= s3_side_nxt;
      s3_rad_pt_r <= s2_pt2_r[PW-1:0];
      s3_rad_mt_r <= (s3_side_nxt.status == STATUS_OK) ? s2_mt2_r[PW-1:0] : '0;
      s3_rad_m_r  <= (s3_side_nxt.status == STATUS_OK) ? s2_m2_r[PW-1:0] : '0;
      s3_a_r      <= a_abs[QW-1:0];
      s3_s_r      <= s_abs[QW-1:0];
      s3_l_r      <= l_abs[QW-1:0];
      s3_d_r      <= d_abs[QW-1:0];
    end
  end

  // square roots
  logic [W-1:0] ptq, mtq, mq;

  pfo_sqrt_pipe #(.RW(PW)) u_sqrt_pt (
    .clk(clk), .en(adv), .rad_i(s3_rad_pt_r), .root_o(ptq));
  pfo_sqrt_pipe #(.RW(PW)) u_sqrt_mt (
    .clk(clk), .en(adv), .rad_i(s3_rad_mt_r), .root_o(mtq));
  pfo_sqrt_pipe #(.RW(PW)) u_sqrt_m (
    .clk(clk), .en(adv), .rad_i(s3_rad_m_r), .root_o(mq));

  logic [SBW+4*QW-1:0] sq_dly_in, sq_dly_out;
  side_t               sq_side;
  logic [QW-1:0]       sq_a, sq_s, sq_l, sq_d;

  assign sq_dly_in = {s3_side_r, s3_a_r, s3_s_r, s3_l_r, s3_d_r};
  assign {sq_side, sq_a, sq_s, sq_l, sq_d} = sq_dly_out;

  pfo_delay #(.WIDTH(SBW + 4 * QW), .DEPTH(W)) u_sq_dly (
    .clk(clk), .en(adv), .d_i(sq_dly_in), .q_o(sq_dly_out));

  // dividers
  logic [QW-1:0] r_num, s_num;
  logic [QW-1:0] q_out, q_side, q_long, q_r, q_s, q_q;

  assign r_num = {{(QW-W-F){1'b0}}, ptq, {F{1'b0}}};
  assign s_num = {{(QW-W-F){1'b0}}, mq, {F{1'b0}}};

  pfo_div_pipe #(.NW(QW), .DW(W)) u_div_out (
    .clk(clk), .en(adv), .num_i(sq_a), .den_i(ptq), .quo_o(q_out));
  pfo_div_pipe #(.NW(QW), .DW(W)) u_div_side (
    .clk(clk), .en(adv), .num_i(sq_s), .den_i(ptq), .quo_o(q_side));
  pfo_div_pipe #(.NW(QW), .DW(W)) u_div_long (
    .clk(clk), .en(adv), .num_i(sq_l), .den_i(mtq), .quo_o(q_long));
  pfo_div_pipe #(.NW(QW), .DW(W)) u_div_r (
    .clk(clk), .en(adv), .num_i(r_num), .den_i(mtq), .quo_o(q_r));
  pfo_div_pipe #(.NW(QW), .DW(W)) u_div_s (
    .clk(clk), .en(adv), .num_i(s_num), .den_i(mtq), .quo_o(q_s));
  pfo_div_pipe #(.NW(QW), .DW(W)) u_div_q (
    .clk(clk), .en(adv), .num_i(sq_d), .den_i(mq), .quo_o(q_q));

  logic [SBW-1:0] dv_side_raw;
  side_t          dv_side;

  pfo_delay #(.WIDTH(SBW), .DEPTH(QW)) u_dv_dly (
    .clk(clk), .en(adv), .d_i(sq_side), .q_o(dv_side_raw));
  assign dv_side = side_t'(dv_side_raw);

  // m1: partial products of out*s and q*r
  logic [H+F:0]    m1_p1l_r, m1_p2l_r;
  logic [QW-H+F:0] m1_p1h_r, m1_p2h_r;
  logic [QW-1:0]   m1_side_r, m1_long_r;
  side_t           m1_sb_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      m1_p1l_r  <= q_out[H-1:0] * q_s[F:0];
      m1_p1h_r  <= q_out[QW-1:H] * q_s[F:0];
      m1_p2l_r  <= q_q[H-1:0] * q_r[F:0];
      m1_p2h_r  <= q_q[QW-1:H] * q_r[F:0];
      m1_side_r <= q_side;
      m1_long_r <= q_long;
      m1_sb_r   <= dv_side;
    end
  end

  // m2: combine and drop fraction bits
  logic [QW+F:0] t1_full, t2_full;
  logic [QW:0]   m2_t1_r, m2_t2_r;
  logic [QW-1:0] m2_side_r, m2_long_r;
  side_t         m2_sb_r;

  always_comb begin
    t1_full = {m1_p1h_r, {H{1'b0}}} + {{(QW-H){1'b0}}, m1_p1l_r};
    t2_full = {m1_p2h_r, {H{1'b0}}} + {{(QW-H){1'b0}}, m1_p2l_r};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m2_t1_r   <= t1_full[QW+F:F];
      m2_t2_r   <= t2_full[QW+F:F];
      m2_side_r <= m1_side_r;
      m2_long_r <= m1_long_r;
      m2_sb_r   <= m1_sb_r;
    end
  end

  // output register: subtract, saturate, mask on status
  logic signed [TW-1:0] t1s, t2s, diff;
  logic [W-1:0]         rest_sat;
  logic signed [W-1:0]  rest_r, side_r, long_r;
  status_t              status_r;

  always_comb begin
    t1s = $signed({2'b00, m2_t1_r});
    t2s = $signed({2'b00, m2_t2_r});
    if (m2_sb_r.a_neg) begin
      t1s = -t1s;
    end
    if (m2_sb_r.d_neg) begin
      t2s = -t2s;
    end
    diff = t1s - t2s;
    if (diff > SAT_HI) begin
      rest_sat = SAT_HI[W-1:0];
    end else if (diff < SAT_LO) begin
      rest_sat = SAT_LO[W-1:0];
    end else begin
      rest_sat = diff[W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      status_r <= m2_sb_r.status;
      if (m2_sb_r.status == STATUS_OK) begin
        rest_r <= rest_sat;
        side_r <= sat_mag(m2_sb_r.s_neg, m2_side_r);
        long_r <= sat_mag(m2_sb_r.l_neg, m2_long_r);
      end else begin
        rest_r <= '0;
        side_r <= '0;
        long_r <= '0;
      end
    end
  end

  assign out_valid     = vld_r[LAT-1];
  assign out_out_rest  = rest_r;
  assign out_side_part = side_r;
  assign out_long_part = long_r;
  assign out_status    = status_r;

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != STATUS_OK |->
      out_out_rest == '0 && out_side_part == '0 && out_long_part == '0)
    else $error("nonzero result with error status");

  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule
`default_nettype wire

>>> dv/tb_pair_frame_out_side_long_projection.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pair_frame_out_side_long_projection
// Drives pair momenta and separation vectors through the projection pipeline.
// A short directed table covers the extremes, the zero transverse momentum
// case, the zero or imaginary mass case and saturation. About 950 random
// requests follow, mostly physical pairs. Each result is checked in order
// against a wide-integer predictor, with random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
module tb_pair_frame_out_side_long_projection;
  import pfo_pkg::*;

  localparam int FRAC_BITS = 16;
  localparam int WORD_BITS = 32;
  localparam int LATENCY   = 3 * WORD_BITS + 7;
  localparam int N_RANDOM  = 950;
  localparam int LIMIT     = 1000000;
  localparam int N_ROWS    = 12;

  typedef logic signed [127:0] wide_t;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] rest;
    logic signed [WORD_BITS-1:0] side;
    logic signed [WORD_BITS-1:0] lng;
    status_t                     st;
  } proj_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] px, py, pz, e, x, y, z, t;
    logic                 typed;
    proj_t                res;
  } row_t;

  localparam proj_t ZPT = '{rest: '0, side: '0, lng: '0, st: STATUS_ZERO_PT};
  localparam proj_t BAD = '{rest: '0, side: '0, lng: '0, st: STATUS_BAD_MASS};
  localparam proj_t NONE = '{rest: '0, side: '0, lng: '0, st: STATUS_OK};

  localparam row_t ROWS [N_ROWS] = '{
    '{0, 0, 0, 0, 0, 0, 0, 0, 1'b1, ZPT},
    '{0, 0, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
      32'h7fffffff, 32'h7fffffff, 1'b1, ZPT},
    '{1, 0, 0, 0, 5, 6, 7, 8, 1'b1, BAD},
    '{3, 4, 0, 5, 1, 1, 1, 1, 1'b1, BAD},
    '{32'h80000000, 32'h80000000, 0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
      32'h7fffffff, 32'h7fffffff, 1'b1, BAD},
    '{1, 0, 0, 2, 0, 0, 0, 0, 1'b0, NONE},
    '{32'h10000, 0, 0, 32'h20000, 32'h10000, 0, 32'h10000, 32'h10000, 1'b0, NONE},
    '{1, 1, 0, 32'h7fffffff, 32'h80000000, 32'h80000000, 32'h80000000,
      32'h80000000, 1'b0, NONE},
    '{32'hffffffff, 1, 32'h80000001, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
      32'h1234, 32'hffff0000, 1'b0, NONE},
    '{32'h7fffffff, 0, 0, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
      32'h7fffffff, 32'h7fffffff, 1'b0, NONE},
    '{32'hffff0000, 32'h10000, 32'hfffe0000, 32'h50000, 32'h30000, 32'hfffd8000,
      32'h8000, 32'h20000, 1'b0, NONE},
    '{1, 1, 32'hffffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
      32'h7fffffff, 32'h80000000, 1'b0, NONE}
  };

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall;
  logic signed [WORD_BITS-1:0] in_sum_px, in_sum_py, in_sum_pz, in_sum_energy;
  logic signed [WORD_BITS-1:0] in_vec_x, in_vec_y, in_vec_z, in_vec_t;
  logic signed [WORD_BITS-1:0] out_out_rest, out_side_part, out_long_part;
  status_t out_status;

  proj_t pending_proj [$];
  proj_t req_typed_res;
  logic  req_typed;
  int    accepted, errors, cycles;
  logic  quiet;

  pair_frame_out_side_long_projection #(
    .FRAC_BITS(FRAC_BITS), .WORD_BITS(WORD_BITS)
  ) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_sum_px(in_sum_px), .in_sum_py(in_sum_py), .in_sum_pz(in_sum_pz),
    .in_sum_energy(in_sum_energy),
    .in_vec_x(in_vec_x), .in_vec_y(in_vec_y), .in_vec_z(in_vec_z),
    .in_vec_t(in_vec_t),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_out_rest(out_out_rest), .out_side_part(out_side_part),
    .out_long_part(out_long_part), .out_status(out_status)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [127:0] isqrt(input logic [127:0] n);
    logic [127:0] root, trial;
    root = '0;
    for (int i = 63; i >= 0; i--) begin
      trial = root | (128'd1 << i);
      if (trial * trial <= n) root = trial;
    end
    return root;
  endfunction

  function automatic logic signed [WORD_BITS-1:0] clamp_word(input wide_t v);
    wide_t hi, lo;
    hi = $signed(128'h7fffffff);
    lo = -$signed(128'h80000000);
    if (v > hi) return hi[WORD_BITS-1:0];
    if (v < lo) return lo[WORD_BITS-1:0];
    return v[WORD_BITS-1:0];
  endfunction

  function automatic proj_t project_pair(
    input logic signed [WORD_BITS-1:0] ipx, ipy, ipz, ie, ix, iy, iz, it);
    wide_t px, py, pz, e, x, y, z, t;
    wide_t pt2, e2, pz2, ptq, mtq, mq, a, sd, l, d;
    wide_t vout, vside, vlong, r, s, q, unit;
    proj_t res;
    px = ipx; py = ipy; pz = ipz; e = ie;
    x = ix; y = iy; z = iz; t = it;
    unit = 128'sd65536;
    res = NONE;
    pt2 = px * px + py * py;
    e2 = e * e;
    pz2 = pz * pz;
    if (pt2 == 0) begin
      res.st = STATUS_ZERO_PT;
      return res;
    end
    if (e2 <= pz2 + pt2) begin
      res.st = STATUS_BAD_MASS;
      return res;
    end
    ptq = $signed(isqrt(pt2));
    mtq = $signed(isqrt(e2 - pz2));
    mq = $signed(isqrt(e2 - pz2 - pt2));
    a = x * px + y * py;
    sd = y * px - x * py;
    l = z * e - t * pz;
    d = e * t - a - pz * z;
    vout = a / ptq;
    vside = sd / ptq;
    vlong = l / mtq;
    r = (ptq * unit) / mtq;
    s = (mq * unit) / mtq;
    q = d / mq;
    res.rest = clamp_word((vout * s) / unit - (q * r) / unit);
    res.side = clamp_word(vside);
    res.lng = clamp_word(vlong);
    return res;
  endfunction

  task automatic report(input string what, input logic [WORD_BITS-1:0] want,
                        input logic [WORD_BITS-1:0] got);
    errors++;
    if (errors <= 40) $display("mismatch %s: expected %h got %h", what, want, got);
  endtask

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("FAIL pair_frame_out_side_long_projection");
      $finish;
    end
  end

  // request side
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      accepted++;
      if (req_typed) pending_proj.push_back(req_typed_res);
      else pending_proj.push_back(project_pair(in_sum_px, in_sum_py, in_sum_pz,
        in_sum_energy, in_vec_x, in_vec_y, in_vec_z, in_vec_t));
    end
  end

  // result side
  always @(posedge clk) begin
    proj_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_proj.size() == 0) begin
        report("unexpected result", '0, out_out_rest);
      end else begin
        want = pending_proj.pop_front();
        if (out_out_rest !== want.rest) report("out_rest", want.rest, out_out_rest);
        if (out_side_part !== want.side) report("side_part", want.side, out_side_part);
        if (out_long_part !== want.lng) report("long_part", want.lng, out_long_part);
        if (out_status !== want.st) report("status", want.st, out_status);
      end
    end
  end

  int stall_left;
  always @(negedge clk) begin
    int pick;
    if (stall_left > 0) begin
      stall_left--;
      out_stall = 1'b1;
    end else begin
      pick = $urandom_range(0, 99);
      if (quiet || pick < 85) out_stall = 1'b0;
      else begin
        out_stall = 1'b1;
        stall_left = (pick < 97) ? $urandom_range(0, 2) : $urandom_range(20, 60);
      end
    end
  end

  task automatic idle_gap();
    int pick, n;
    pick = $urandom_range(0, 99);
    n = 0;
    if (!quiet) begin
      if (pick >= 95) n = $urandom_range(10, 40);
      else if (pick >= 70) n = $urandom_range(1, 3);
    end
    if (n > 0) begin
      in_valid = 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  task automatic send(input logic [WORD_BITS-1:0] px, py, pz, e, x, y, z, t,
                      input logic typed, input proj_t res);
    int seen;
    idle_gap();
    in_sum_px = px; in_sum_py = py; in_sum_pz = pz; in_sum_energy = e;
    in_vec_x = x; in_vec_y = y; in_vec_z = z; in_vec_t = t;
    req_typed = typed;
    req_typed_res = res;
    in_valid = 1'b1;
    seen = accepted;
    do @(negedge clk); while (accepted == seen);
  endtask

  function automatic logic [WORD_BITS-1:0] rand_scaled();
    int sh;
    sh = $urandom_range(0, 30);
    return $signed($urandom()) >>> sh;
  endfunction

  initial begin
    logic [WORD_BITS-1:0] px, py, pz, e;
    longint mag;
    int kind;
    rst_n = 1'b0;
    in_valid = 1'b0;
    out_stall = 1'b0;
    stall_left = 0;
    quiet = 1'b0;
    req_typed = 1'b0;
    req_typed_res = NONE;
    {in_sum_px, in_sum_py, in_sum_pz, in_sum_energy} = '0;
    {in_vec_x, in_vec_y, in_vec_z, in_vec_t} = '0;
    accepted = 0; errors = 0; cycles = 0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    foreach (ROWS[i])
      send(ROWS[i].px, ROWS[i].py, ROWS[i].pz, ROWS[i].e, ROWS[i].x, ROWS[i].y,
           ROWS[i].z, ROWS[i].t, ROWS[i].typed, ROWS[i].res);

    for (int n = 0; n < N_RANDOM; n++) begin
      quiet = (n >= 200 && n < 300);
      if (n == 500) begin
        in_valid = 1'b0;
        while (pending_proj.size() != 0) @(negedge clk);
      end
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        // physical pair: energy magnitude above the momentum magnitude unless clamped
        px = rand_scaled(); py = rand_scaled(); pz = rand_scaled();
        mag = longint'($signed(px) < 0 ? -$signed(px) : $signed(px))
            + longint'($signed(py) < 0 ? -$signed(py) : $signed(py))
            + longint'($signed(pz) < 0 ? -$signed(pz) : $signed(pz))
            + longint'($urandom_range(1, 1 << $urandom_range(0, 30)));
        if (mag > 64'sh7fffffff) mag = 64'sh7fffffff;
        e = mag[WORD_BITS-1:0];
        if ($urandom_range(0, 3) == 0) e = -e;
      end else if (kind < 80) begin
        px = 0; py = 0; pz = $urandom(); e = $urandom();
      end else begin
        px = $urandom(); py = $urandom(); pz = $urandom(); e = $urandom();
      end
      send(px, py, pz, e, $urandom(), $urandom(), $urandom(), $urandom(), 1'b0, NONE);
    end
    in_valid = 1'b0;

    while (pending_proj.size() != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);
    if (errors == 0) $display("PASS pair_frame_out_side_long_projection");
    else $display("FAIL pair_frame_out_side_long_projection");
    $finish;
  end

endmodule
